/* rtl/cpst_pkg.sv */
// Shared constants and types for the convex polygon span table unit.
// No dependencies; used by convex_polygon_span_table_unit.
`timescale 1ns / 1ps
`default_nettype none

package cpst_pkg;

    // default geometry
    localparam int ROWS_DEFAULT   = 1024;
    localparam int X_BITS_DEFAULT = 12;

    // fixed field widths
    localparam int XW  = 12;   // vertex x
    localparam int YW  = 10;   // vertex y and row numbers
    localparam int AW  = 23;   // byte address
    localparam int LW  = 12;   // span length field
    localparam int WCW = 10;   // word count field
    localparam int PW  = 14;   // row pitch register
    localparam int CW  = 8;    // fill color register

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = PW;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 4'd1;

    localparam logic [PW-1:0]  PITCH_RESET   = 14'd1024;
    localparam logic [CW-1:0]  COLOR_RESET   = 8'd0;
    localparam logic [YW-1:0]  MIN_ROW_RESET = 10'd1023;
    localparam logic [YW-1:0]  MAX_ROW_RESET = 10'd0;

    // operation selector
    typedef logic [1:0] t_op;
    localparam t_op OP_CLEAR = 2'd0;
    localparam t_op OP_EDGE  = 2'd1;
    localparam t_op OP_QUERY = 2'd2;

    // stream widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 104;

endpackage

`default_nettype wire

/* rtl/convex_polygon_span_table_unit.sv */
// Convex polygon span table unit: edge scan conversion into span tables
// and fill-span queries. Depends on cpst_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each input beat is one operation selected by tuser: clear the row
// bounds, add a polygon edge, or query the fill span of one row; each
// produces exactly one result beat. Clear and unused ops go straight to
// the result; a query does the table read, then address/length, then the
// byte split. An edge walks through |dy| + 1 row writes and the x steps of
// the DDA (about |dx|), one row or one x step per cycle through the table
// write port; a horizontal edge skips the walk and writes no row. After
// reset the two span tables are zeroed by a clearing pass over all ROWS
// rows during which no beat is taken; configuration writes are accepted at
// any time. A finished result waits in the output register while the next
// beat is taken.
module convex_polygon_span_table_unit #(
    parameter int ROWS   = cpst_pkg::ROWS_DEFAULT,
    parameter int X_BITS = cpst_pkg::X_BITS_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata from bit 0: x_from(12) y_from(10) x_to(12) y_to(10) query_row(10), pad
    input  wire logic [cpst_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // tuser: op(2)
    input  wire logic [1:0]                     i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // tdata from bit 0: byte_address(23) span_length(12) lead_bytes(2)
    // word_count(10) trail_bytes(2) fill_word(32) lowest_row(10)
    // highest_row(10), pad
    output logic [cpst_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // tuser: in_range(1)
    output logic                                o_m_axis_tuser,
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [cpst_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cpst_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RAW = $clog2(ROWS);
    localparam int YW  = cpst_pkg::YW;
    localparam int XW  = cpst_pkg::XW;
    localparam int ACW = XW + 1;   // DDA accumulator

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_QRD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // input fields
    logic [XW-1:0]       in_xf, in_xt;
    logic [YW-1:0]       in_yf, in_yt, in_q;
    cpst_pkg::t_op       in_op;
    assign in_xf = i_s_axis_tdata[11:0];
    assign in_yf = i_s_axis_tdata[21:12];
    assign in_xt = i_s_axis_tdata[33:22];
    assign in_yt = i_s_axis_tdata[43:34];
    assign in_q  = i_s_axis_tdata[53:44];
    assign in_op = i_s_axis_tuser;

    // control and working registers
    logic [1:0]          r_state;
    logic                r_clr_busy;
    logic [RAW-1:0]      r_clr_addr;
    logic [cpst_pkg::PW-1:0] r_pitch;
    logic [cpst_pkg::CW-1:0] r_color;
    logic [YW-1:0]       r_min, r_max;
    logic                r_hit, r_qok;
    logic [23:0]         r_prod;
    logic [cpst_pkg::AW-1:0] r_addr;
    logic [X_BITS-1:0]   r_len;
    logic [X_BITS-1:0]   r_rd_left, r_rd_right;
    // DDA walk
    logic [XW-1:0]       r_sx, r_adx;
    logic [ACW-1:0]      r_acc;
    logic [YW-1:0]       r_den, r_row, r_cnt;
    logic                r_neg_step, r_strict, r_right;
    // output register
    logic                r_ovalid, r_orange;
    logic [cpst_pkg::AW-1:0] r_oaddr;
    logic [cpst_pkg::LW-1:0] r_olen;
    logic [1:0]          r_olead, r_otrail;
    logic [cpst_pkg::WCW-1:0] r_owords;
    logic [31:0]         r_ofill;
    logic [YW-1:0]       r_olow, r_ohigh;

    logic [X_BITS-1:0]   mem_left  [ROWS];
    logic [X_BITS-1:0]   mem_right [ROWS];

    logic accept, out_free, walk_step, walk_last, row_ok;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // edge setup: orient the edge downward and pick its table
    logic [YW:0]   e_dy;
    logic          e_up;
    logic [XW:0]   e_dx, e_dxp;
    logic [YW-1:0] e_lo, e_hi;
    always_comb begin
        e_dy  = {1'b0, in_yt} - {1'b0, in_yf};
        e_up  = e_dy[YW];
        e_dx  = {1'b0, in_xt} - {1'b0, in_xf};
        e_dxp = e_up ? (~e_dx + 1'b1) : e_dx;
        e_lo  = (in_yf < in_yt) ? in_yf : in_yt;
        e_hi  = (in_yf < in_yt) ? in_yt : in_yf;
    end

    // DDA decision: x step pending or row write
    always_comb begin
        if (r_strict) begin
            walk_step = r_acc > {{(ACW-YW){1'b0}}, r_den};
        end else begin
            walk_step = r_acc >= {{(ACW-YW){1'b0}}, r_den};
        end
        walk_last = (r_cnt == '0);
        row_ok    = 32'(r_row) < ROWS;
    end

    // table write port: clearing pass or walk row write
    logic            wr_left, wr_right;
    logic [RAW-1:0]  wr_addr;
    logic [X_BITS-1:0] wr_data;
    always_comb begin
        wr_left  = 1'b0;
        wr_right = 1'b0;
        wr_addr  = RAW'(r_row);
        wr_data  = X_BITS'(r_sx);
        if (r_clr_busy) begin
            wr_left  = 1'b1;
            wr_right = 1'b1;
            wr_addr  = r_clr_addr;
            wr_data  = '0;
        end else if (r_state == S_WALK && !walk_step && row_ok) begin
            wr_left  = !r_right;
            wr_right = r_right;
        end
    end

    // span tables, synchronous read
    always_ff @(posedge i_clk) begin
        if (wr_left) begin
            mem_left[wr_addr] <= wr_data;
        end
        if (wr_right) begin
            mem_right[wr_addr] <= wr_data;
        end
        r_rd_left  <= mem_left[RAW'(in_q)];
        r_rd_right <= mem_right[RAW'(in_q)];
    end

    // query stage: span start, end and length
    logic [X_BITS-1:0] q_start, q_end;
    always_comb begin
        q_start = r_qok ? r_rd_left  : '0;
        q_end   = r_qok ? r_rd_right : '0;
    end

    // final stage: lead, word and trail split
    logic [1:0]        f_lead0, f_lead;
    logic [X_BITS-1:0] f_rest;
    always_comb begin
        f_lead0 = 2'd0 - r_addr[1:0];
        if (X_BITS'(f_lead0) > r_len) begin
            f_lead = r_len[1:0];
        end else begin
            f_lead = f_lead0;
        end
        f_rest = r_len - X_BITS'(f_lead);
    end

    // control state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_pitch    <= cpst_pkg::PITCH_RESET;
            r_color    <= cpst_pkg::COLOR_RESET;
            r_min      <= cpst_pkg::MIN_ROW_RESET;
            r_max      <= cpst_pkg::MAX_ROW_RESET;
            r_ovalid   <= 1'b0;
        end else begin
            // clearing sweep after reset
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == RAW'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cpst_pkg::REG_ROW_PITCH:  r_pitch <= i_cfg_data;
                    cpst_pkg::REG_FILL_COLOR: r_color <= i_cfg_data[cpst_pkg::CW-1:0];
                    default: ;
                endcase
            end

            // result handshake: load on finish, drop when taken
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_hit <= (in_op == cpst_pkg::OP_QUERY) && (in_q >= r_min)
                                 && (in_q < r_max);
                        case (in_op)
                            cpst_pkg::OP_CLEAR: begin
                                r_min   <= cpst_pkg::MIN_ROW_RESET;
                                r_max   <= cpst_pkg::MAX_ROW_RESET;
                                r_state <= S_FIN;
                            end
                            cpst_pkg::OP_EDGE: begin
                                if (e_dy != '0) begin
                                    if (e_lo < r_min) r_min <= e_lo;
                                    if (e_hi > r_max) r_max <= e_hi;
                                    r_state <= S_WALK;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            cpst_pkg::OP_QUERY: begin
                                r_state <= S_QRD;
                            end
                            default: r_state <= S_FIN;
                        endcase
                        // walk and query setup
                        r_right    <= e_up;
                        r_sx       <= e_up ? in_xt : in_xf;
                        r_row      <= e_up ? in_yt : in_yf;
                        r_den      <= e_up ? (in_yf - in_yt) : (in_yt - in_yf);
                        r_cnt      <= e_up ? (in_yf - in_yt) : (in_yt - in_yf);
                        r_acc      <= ACW'(e_up ? (in_yf - in_yt) : (in_yt - in_yf)) >> 1;
                        r_adx      <= e_dxp[XW] ? XW'(~e_dxp + 1'b1) : e_dxp[XW-1:0];
                        r_neg_step <= e_dxp[XW];
                        r_strict   <= e_up ? e_dxp[XW] : !e_dxp[XW];
                        r_qok      <= 32'(in_q) < ROWS;
                        r_prod     <= {14'd0, in_q} * {10'd0, r_pitch};
                    end
                end
                S_WALK: begin
                    if (walk_step) begin
                        r_sx  <= r_neg_step ? (r_sx - 1'b1) : (r_sx + 1'b1);
                        r_acc <= r_acc - {{(ACW-YW){1'b0}}, r_den};
                    end else begin
                        r_row <= r_row + 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                        r_acc <= r_acc + {{(ACW-XW){1'b0}}, r_adx};
                        if (walk_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_QRD: begin
                    r_addr  <= cpst_pkg::AW'(r_prod + 24'(q_start));
                    r_len   <= (q_end > q_start) ? (q_end - q_start) : '0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_orange <= r_hit;
            r_olow   <= r_min;
            r_ohigh  <= r_max;
            if (r_hit) begin
                r_oaddr  <= r_addr;
                r_olen   <= cpst_pkg::LW'(r_len);
                r_olead  <= f_lead;
                r_owords <= cpst_pkg::WCW'(f_rest >> 2);
                r_otrail <= f_rest[1:0];
                r_ofill  <= {4{r_color}};
            end else begin
                r_oaddr  <= '0;
                r_olen   <= '0;
                r_olead  <= '0;
                r_owords <= '0;
                r_otrail <= '0;
                r_ofill  <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_orange;
    assign o_m_axis_tdata  = {3'd0, r_ohigh, r_olow, r_ofill, r_otrail, r_owords,
                              r_olead, r_olen, r_oaddr};

    // checks
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("beat taken while previous operation in flight");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_clr_busy) |-> !(wr_left || wr_right))
        else $error("table written while idle");

    a_acc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |->
            (r_acc <= ({{(ACW-YW){1'b0}}, r_den} + {{(ACW-XW){1'b0}}, r_adx})))
        else $error("DDA accumulator out of bounds");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata[80:0] == '0))
        else $error("span fields set for a row out of range");

    a_lead_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ({10'd0, o_m_axis_tdata[36:35]} <= o_m_axis_tdata[34:23]))
        else $error("lead bytes exceed span length");

endmodule

`default_nettype wire

/* bench/convex_polygon_span_table_unit_tb.sv */
// Self-checking bench for convex_polygon_span_table_unit: directed rows, then random
// polygons, edges and row queries, checked against an in-bench span table predictor.
// Depends on cpst_pkg and the unit RTL.
`timescale 1ns / 1ps

module convex_polygon_span_table_unit_tb;
    import cpst_pkg::*;

    localparam int  TABLE_ROWS    = ROWS_DEFAULT;
    localparam t_op OP_UNUSED     = 2'd3;
    localparam int  PHASES        = 8;
    localparam int  PHASE_BEATS   = 250;
    localparam int  CYCLE_LIMIT   = 4_000_000;
    localparam int  SETTLE_CYCLES = 100;
    localparam int  MAX_REPORTS   = 10;

    // one result beat, laid out as {tuser, tdata} without the pad
    typedef struct packed {
        logic           in_range;
        logic [YW-1:0]  highest;
        logic [YW-1:0]  lowest;
        logic [31:0]    fill;
        logic [1:0]     trail;
        logic [WCW-1:0] words;
        logic [1:0]     lead;
        logic [LW-1:0]  len;
        logic [AW-1:0]  addr;
    } t_span_result;

    // directed stimulus row; typed rows carry their row bounds, all else zero
    typedef struct packed {
        t_op           op;
        logic [XW-1:0] xf;
        logic [YW-1:0] yf;
        logic [XW-1:0] xt;
        logic [YW-1:0] yt;
        logic [YW-1:0] q;
        logic          typed;
        logic [YW-1:0] low;
        logic [YW-1:0] high;
    } t_stim_row;

    localparam t_stim_row DIRECTED [23] = '{
        '{OP_QUERY,     0,    0,    0,    0,    5, 1, 1023,    0},  // fresh after reset
        '{OP_UNUSED, 4095, 1023, 4095, 1023, 1023, 1, 1023,    0},  // unused op, all ones
        '{OP_EDGE,      0,   10, 4095,   10,    0, 1, 1023,    0},  // horizontal, skipped
        '{OP_EDGE,      0,    0, 4095, 1023,    0, 1,    0, 1023},  // full-height left edge
        '{OP_EDGE,   4095, 1023, 4095,    0,    0, 1,    0, 1023},  // vertical right edge
        '{OP_QUERY,     0,    0,    0,    0,    0, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0,  511, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0, 1022, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0, 1023, 1,    0, 1023},  // max row is exclusive
        '{OP_CLEAR,     0,    0,    0,    0,    0, 1, 1023,    0},
        '{OP_QUERY,     0,    0,    0,    0,  511, 1, 1023,    0},  // bounds cleared
        '{OP_EDGE,    100,   20,   40,   60,    0, 1,   20,   60},  // left, x going left
        '{OP_EDGE,     40,   60,  120,  100,    0, 1,   20,  100},  // left, x going right
        '{OP_EDGE,    120,  100,  200,   50,    0, 1,   20,  100},  // right, walked leftward
        '{OP_EDGE,    200,   50,  100,   20,    0, 1,   20,  100},  // right, walked rightward
        '{OP_QUERY,     0,    0,    0,    0,   20, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0,   55, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0,   99, 0,    0,    0},
        '{OP_QUERY,     0,    0,    0,    0,  100, 1,   20,  100},
        '{OP_EDGE,    300,  200,  300,  210,    0, 1,   20,  210},  // start right of end
        '{OP_EDGE,     10,  210,   10,  200,    0, 1,   20,  210},
        '{OP_QUERY,     0,    0,    0,    0,  205, 0,    0,    0},  // negative span
        '{OP_CLEAR,     0,    0,    0,    0,    0, 1, 1023,    0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tuser;
    wire                   cfg_ready;

    // predictor state
    logic [XW-1:0] span_start_x [TABLE_ROWS];
    logic [XW-1:0] span_end_x [TABLE_ROWS];
    logic [YW-1:0] low_row      = MIN_ROW_RESET;
    logic [YW-1:0] high_row     = MAX_ROW_RESET;
    logic [PW-1:0] pitch_shadow = PITCH_RESET;
    logic [CW-1:0] color_shadow = COLOR_RESET;

    t_span_result pending_spans [$];
    int           beats_sent  = 0;
    int           fault_count = 0;
    int           cycle_count = 0;
    bit           send_burst  = 1'b0;
    bit           recv_burst  = 1'b0;

    always #4 clk = ~clk;

    convex_polygon_span_table_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // wait before the next beat; bursts with no idling come and go at random
    function automatic int draw_gap(ref bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 18));
    endfunction

    // DDA walk of one edge into a span table, one entry per row
    function automatic void trace_edge(bit right_side, int sx, int sy, int dx, int dy);
        int  acc;
        int  stride;
        int  adx;
        int  row;
        bit  strict;
        acc    = dy >> 1;
        stride = (dx >= 0) ? 1 : -1;
        adx    = (dx >= 0) ? dx : -dx;
        // tie goes the other way for left/right-going edges on each side
        strict = right_side ? (dx < 0) : (dx >= 0);
        row    = sy;
        for (int n = 0; n <= dy; n++) begin
            if (row >= 0 && row < TABLE_ROWS) begin
                if (right_side)
                    span_end_x[row] = sx[XW-1:0];
                else
                    span_start_x[row] = sx[XW-1:0];
            end
            row++;
            acc += adx;
            while (strict ? (acc > dy) : (acc >= dy)) begin
                sx  += stride;
                acc -= dy;
            end
        end
    endfunction

    // apply one operation to the predicted state and return its result beat
    function automatic t_span_result rasterize_beat(t_op op, int xf, int yf, int xt, int yt,
                                                    int q);
        t_span_result r;
        int x_lo;
        int x_hi;
        int width;
        int addr;
        int lead;
        int rest;
        r = '0;
        case (op)
            OP_CLEAR: begin
                low_row  = MIN_ROW_RESET;
                high_row = MAX_ROW_RESET;
            end
            OP_EDGE: begin
                if (yt < yf) begin
                    // upward edge: right side, walked from its upper end
                    if (yt < low_row)  low_row  = yt;
                    if (yf > high_row) high_row = yf;
                    trace_edge(1'b1, xt, yt, xf - xt, yf - yt);
                end else if (yt > yf) begin
                    if (yf < low_row)  low_row  = yf;
                    if (yt > high_row) high_row = yt;
                    trace_edge(1'b0, xf, yf, xt - xf, yt - yf);
                end
            end
            OP_QUERY: begin
                if (q >= low_row && q < high_row) begin
                    x_lo  = span_start_x[q];
                    x_hi  = span_end_x[q];
                    width = (x_hi > x_lo) ? x_hi - x_lo : 0;
                    addr  = q * pitch_shadow + x_lo;
                    lead  = (-addr) & 3;
                    if (lead > width)
                        lead = width;
                    rest  = width - lead;
                    r.in_range = 1'b1;
                    r.addr     = addr[AW-1:0];
                    r.len      = width[LW-1:0];
                    r.lead     = lead[1:0];
                    r.words    = rest[WCW+1:2];
                    r.trail    = rest[1:0];
                    r.fill     = {4{color_shadow}};
                end
            end
            default: ;
        endcase
        r.lowest  = low_row;
        r.highest = high_row;
        return r;
    endfunction

    // one input beat; the prediction is taken when the beat is accepted
    task automatic send_beat(t_op op, int xf, int yf, int xt, int yt, int q,
                             logic typed = 1'b0, logic [YW-1:0] want_low = '0,
                             logic [YW-1:0] want_high = '0);
        t_span_result want;
        int           gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= op;
        s_tdata  <= {2'b00, q[YW-1:0], yt[YW-1:0], xt[XW-1:0], yf[YW-1:0], xf[XW-1:0]};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready === 1'b1));
        want = rasterize_beat(op, xf, yf, xt, yt, q);
        if (typed) begin
            want         = '0;
            want.lowest  = want_low;
            want.highest = want_high;
        end
        pending_spans.push_back(want);
        if (op != OP_UNUSED)
            beats_sent++;
    endtask

    // write both registers back to back, lowering valid only after the last
    task automatic program_raster(int pitch, int color);
        for (int i = 0; i < 2; i++) begin
            cfg_index <= (i == 0) ? REG_ROW_PITCH : REG_FILL_COLOR;
            cfg_data  <= (i == 0) ? pitch[PW-1:0] : CFG_DATA_W'(color[CW-1:0]);
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!(cfg_valid && cfg_ready === 1'b1));
            if (i == 0)
                pitch_shadow = pitch[PW-1:0];
            else
                color_shadow = color[CW-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge clk);
    endtask

    // clear (most times), walk the edges of a random diamond, then ask for rows around it
    task automatic send_polygon();
        int vx [4];
        int vy [4];
        int tall;
        int wide;
        int y_top;
        int x_left;
        int a;
        int b;
        int q;
        bit bulky;
        bit reversed;
        bulky    = ($urandom_range(0, 29) == 0);
        reversed = ($urandom_range(0, 9) == 0);
        tall     = bulky ? $urandom_range(0, 511) : $urandom_range(0, 63);
        wide     = bulky ? $urandom_range(0, 2047) : $urandom_range(0, 127);
        y_top    = $urandom_range(0, 1023 - tall);
        x_left   = $urandom_range(0, 4095 - wide);
        vx[0] = $urandom_range(x_left, x_left + wide);
        vy[0] = y_top;
        vx[1] = x_left;
        vy[1] = $urandom_range(y_top, y_top + tall);
        vx[2] = $urandom_range(x_left, x_left + wide);
        vy[2] = y_top + tall;
        vx[3] = x_left + wide;
        vy[3] = $urandom_range(y_top, y_top + tall);
        if ($urandom_range(0, 9) != 0)
            send_beat(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 1023),
                      $urandom_range(0, 4095), $urandom_range(0, 1023),
                      $urandom_range(0, 1023));
        // now and then clockwise, or with an edge missing
        for (int k = 0; k < 4; k++) begin
            a = reversed ? 3 - k : k;
            b = reversed ? (a + 3) % 4 : (a + 1) % 4;
            if ($urandom_range(0, 19) != 0)
                send_beat(OP_EDGE, vx[a], vy[a], vx[b], vy[b], $urandom_range(0, 1023));
        end
        repeat ($urandom_range(2, 8)) begin
            q = $urandom_range(0, tall + 4);
            q = clip(q + y_top - 2, 1023);
            send_beat(OP_QUERY, $urandom_range(0, 4095), $urandom_range(0, 1023),
                      $urandom_range(0, 4095), $urandom_range(0, 1023), q);
        end
    endtask

    // any op with random fields; edges mostly short
    task automatic send_noise();
        t_op op;
        int  xf;
        int  yf;
        int  xt;
        int  yt;
        op = t_op'($urandom_range(0, 3));
        xf = $urandom_range(0, 4095);
        yf = $urandom_range(0, 1023);
        if ($urandom_range(0, 39) == 0) begin
            xt = $urandom_range(0, 4095);
            yt = $urandom_range(0, 1023);
        end else begin
            xt = $urandom_range(0, 200);
            xt = clip(xf + xt - 100, 4095);
            yt = $urandom_range(0, 60);
            yt = clip(yf + yt - 30, 1023);
        end
        send_beat(op, xf, yf, xt, yt, $urandom_range(0, 1023));
    endtask

    // result sink with random stalls; checks each beat against the oldest prediction
    initial begin : result_sink
        int           stall;
        t_span_result got;
        t_span_result want;
        forever begin
            stall = draw_gap(recv_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready));
            got = {m_tuser, m_tdata[$bits(t_span_result)-2:0]};
            if (pending_spans.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected", $realtime);
            end else begin
                want = pending_spans.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp rng=%0d addr=%0d len=%0d lead=%0d words=%0d",
                                 $realtime, want.in_range, want.addr, want.len, want.lead,
                                 want.words);
                        $display("    exp trail=%0d fill=%h low=%0d high=%0d",
                                 want.trail, want.fill, want.lowest, want.highest);
                        $display("    got rng=%0d addr=%0d len=%0d lead=%0d words=%0d",
                                 got.in_range, got.addr, got.len, got.lead, got.words);
                        $display("    got trail=%0d fill=%h low=%0d high=%0d",
                                 got.trail, got.fill, got.lowest, got.highest);
                    end
                end
            end
        end
    end

    // run limit, covers the clearing pass and the slowest legal stimulus
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        foreach (span_start_x[r]) begin
            span_start_x[r] = '0;
            span_end_x[r]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at extreme pitch and color
        program_raster(8192, 255);
        foreach (DIRECTED[i])
            send_beat(DIRECTED[i].op, DIRECTED[i].xf, DIRECTED[i].yf, DIRECTED[i].xt,
                      DIRECTED[i].yt, DIRECTED[i].q, DIRECTED[i].typed, DIRECTED[i].low,
                      DIRECTED[i].high);
        drain_results();
        beats_sent = 0;

        // random phases, each with its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       program_raster(1, 0);
                1:       program_raster(8192, 255);
                2:       program_raster(PITCH_RESET, 8'h5A);
                default: program_raster($urandom_range(1, 8192), $urandom_range(0, 255));
            endcase
            while (beats_sent < (p + 1) * PHASE_BEATS) begin
                if ($urandom_range(0, 4) != 0)
                    send_polygon();
                else
                    send_noise();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_spans.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/cpst_pkg.sv
rtl/convex_polygon_span_table_unit.sv
bench/convex_polygon_span_table_unit_tb.sv
